// ===== rtl/tas_pkg.sv =====
// ----------------------------------------------------------------------------
// tas_pkg
// Shared types and constants for the temperature average and slope block.
// ----------------------------------------------------------------------------
package tas_pkg;

    localparam int SAMPLE_DEPTH_DEF = 64;
    localparam int RATE_DEPTH_DEF   = 16;
    localparam int TEMP_SCALE_DEF   = 1000;

    localparam int MS_PER_S = 1000;

    // divider operand widths: rate numerator is below 2^50, divisor below 2^48
    localparam int DVD_W = 51;
    localparam int DVS_W = 48;

    localparam int CFG_W = 7;

    typedef enum logic [0:0] {
        REG_SAMPLE_WINDOW = 1'b0,
        REG_SLOPE_WINDOW  = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic signed [23:0] raw_temp;
        logic        [31:0] now_ms;
    } sample_t;

    typedef struct packed {
        logic signed [23:0] avg_temp;
        logic               avg_valid;
        logic               avg_updated;
        logic signed [31:0] slope_q16;
    } result_t;

endpackage

// ===== rtl/tas_div.sv =====
// ----------------------------------------------------------------------------
// tas_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tas_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       go,
    input  logic [tas_pkg::DVD_W-1:0]  dividend,
    input  logic [tas_pkg::DVS_W-1:0]  divisor,
    output logic                       done,
    output logic [tas_pkg::DVD_W-1:0]  quotient,
    output logic [tas_pkg::DVS_W-1:0]  remainder
);
    import tas_pkg::*;

    localparam int CW = $clog2(DVD_W + 1);

    logic              busy_reg;
    logic              done_reg;
    logic [CW-1:0]     cnt_reg;
    logic [DVD_W-1:0]  q_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVS_W:0]    trial;
    logic [DVS_W:0]    diff;
    logic              fits;

    assign trial = {rem_reg, q_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[DVD_W-2:0], fits};
            rem_reg <= fits ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/temperature_average_and_slope.sv =====
// ----------------------------------------------------------------------------
// temperature_average_and_slope
// Boxcar mean of temperature samples with a Q16.16 slope estimate.
// ----------------------------------------------------------------------------
// Sequence: a request with sample_window zero goes straight to the result;
//   otherwise the rate, slope and average divides make three passes through
//   the shared divider, fewer when a divide or a sum is skipped.
// Throughput: one request at a time; the divider and the serial sums set it.
// Reset: clears all state, rings read as zero until written.
module temperature_average_and_slope #(
    parameter int SAMPLE_DEPTH = tas_pkg::SAMPLE_DEPTH_DEF,
    parameter int RATE_DEPTH   = tas_pkg::RATE_DEPTH_DEF,
    parameter int TEMP_SCALE   = tas_pkg::TEMP_SCALE_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  tas_pkg::sample_t         sample,
    output logic                     out_valid,
    input  logic                     out_ready,
    output tas_pkg::result_t         result,
    input  logic                     cfg_we,
    input  tas_pkg::cfg_index_t      cfg_index,
    input  logic [tas_pkg::CFG_W-1:0] cfg_data
);
    import tas_pkg::*;

    localparam int AW     = $clog2(SAMPLE_DEPTH);
    localparam int CNT_W  = $clog2(SAMPLE_DEPTH + 1);
    localparam int NW     = CNT_W > 7 ? CNT_W : 7;
    localparam int RAW    = $clog2(RATE_DEPTH);
    localparam int RCNT_W = $clog2(RATE_DEPTH + 1);
    localparam int MW     = RCNT_W > 5 ? RCNT_W : 5;
    localparam int SUM_W  = 24 + CNT_W;
    localparam int RSUM_W = 32 + RCNT_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_RMUL  = 10'b0000000010,
        S_RDIV  = 10'b0000000100,
        S_RPUSH = 10'b0000001000,
        S_SSUM  = 10'b0000010000,
        S_SDIV  = 10'b0000100000,
        S_ASUM  = 10'b0001000000,
        S_ADIV  = 10'b0010000000,
        S_AFIN  = 10'b0100000000,
        S_DONE  = 10'b1000000000
    } state_t;

    state_t state_reg;

    logic [6:0] sw_reg;
    logic [4:0] slw_reg;

    logic signed [23:0] smp_mem [SAMPLE_DEPTH];
    logic [SAMPLE_DEPTH-1:0] smp_vld_reg;
    logic signed [23:0] rd_data_reg;
    logic               rd_vld_reg;
    logic               pipe_reg;

    logic signed [31:0] rate_ring_reg [RATE_DEPTH];
    logic [AW-1:0]      pos_reg;
    logic               filled_reg;
    logic [RAW-1:0]     rpos_reg;
    logic signed [23:0] temp_now_reg;
    logic signed [23:0] temp_prev_reg;
    logic [31:0]        time_now_reg;
    logic [31:0]        time_prev_reg;
    logic signed [31:0] slope_reg;
    logic [31:0]        now_in_reg;
    logic               upd_reg;

    logic [CNT_W-1:0]         scnt_reg;
    logic [RCNT_W-1:0]        rcnt_reg;
    logic signed [SUM_W-1:0]  acc_reg;
    logic signed [RSUM_W-1:0] rsum_reg;
    logic                     neg_reg;

    logic              div_go_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic              div_done;
    logic [DVD_W-1:0]  div_q;
    logic [DVS_W-1:0]  div_r;

    result_t out_reg;
    logic    out_valid_reg;

    // effective windows
    logic [NW-1:0]     n_wide;
    logic [CNT_W-1:0]  n_eff;
    logic [MW-1:0]     m_wide;
    logic [RCNT_W-1:0] m_eff;

    always_comb
    begin
        n_wide = NW'(sw_reg) > NW'(SAMPLE_DEPTH) ? NW'(SAMPLE_DEPTH) : NW'(sw_reg);
        n_eff  = CNT_W'(n_wide);
        m_wide = (slw_reg == 5'd0) ? MW'(1) : MW'(slw_reg);
        if (m_wide > MW'(RATE_DEPTH))
            m_wide = MW'(RATE_DEPTH);
        m_eff  = RCNT_W'(m_wide);
    end

    // sample position advance
    logic [CNT_W-1:0] pos_inc;
    logic             pos_wrap;
    assign pos_inc  = CNT_W'(pos_reg) + 1'b1;
    assign pos_wrap = pos_inc >= n_eff;

    logic [RCNT_W-1:0] rpos_inc;
    assign rpos_inc = RCNT_W'(rpos_reg) + 1'b1;

    // rate operands
    logic signed [24:0] d_temp;
    logic [24:0]        d_temp_abs;
    logic [31:0]        d_time;
    logic [31:0]        d_time_abs;
    logic [34:0]        num_prod;
    logic [48:0]        den_prod;
    assign d_temp     = 25'(temp_now_reg) - 25'(temp_prev_reg);
    assign d_temp_abs = d_temp[24] ? 25'(-d_temp) : 25'(d_temp);
    assign d_time     = time_now_reg - time_prev_reg;
    assign d_time_abs = d_time[31] ? -d_time : d_time;
    assign num_prod   = 35'(d_temp_abs) * 35'(MS_PER_S);
    assign den_prod   = 49'(17'(TEMP_SCALE)) * 49'(d_time_abs);

    // saturated rate from the quotient
    logic signed [31:0] rate_sat;
    always_comb
    begin
        if (neg_reg)
            rate_sat = (|div_q[DVD_W-1:31]) ? 32'sh8000_0000 : -$signed(div_q[31:0]);
        else
            rate_sat = (|div_q[DVD_W-1:31]) ? 32'sh7FFF_FFFF : $signed(div_q[31:0]);
    end

    // round half to even on the floor quotient
    logic signed [25:0] q_fl;
    logic [CNT_W-1:0]   r_fl;
    logic [CNT_W:0]     r_twice;
    logic signed [25:0] q_rnd;
    always_comb
    begin
        q_fl = neg_reg ? -$signed({1'b0, div_q[24:0]}) : $signed({1'b0, div_q[24:0]});
        r_fl = CNT_W'(div_r);
        if (neg_reg && (r_fl != '0))
        begin
            q_fl = q_fl - 26'sd1;
            r_fl = n_eff - r_fl;
        end
        r_twice = {r_fl, 1'b0};
        q_rnd   = q_fl;
        if ((r_twice > (CNT_W + 1)'(n_eff)) ||
            ((r_twice == (CNT_W + 1)'(n_eff)) && q_fl[0]))
            q_rnd = q_fl + 26'sd1;
    end

    logic in_acc;
    logic out_free;
    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sw_reg  <= 7'd16;
            slw_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SAMPLE_WINDOW: sw_reg  <= cfg_data;
                REG_SLOPE_WINDOW:  slw_reg <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // sample memory
    logic smp_we;
    assign smp_we = in_acc && (sw_reg != 7'd0);

    always_ff @(posedge clk)
    begin
        if (smp_we)
            smp_mem[pos_reg] <= sample.raw_temp;
        rd_data_reg <= smp_mem[scnt_reg[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (smp_we)
                smp_vld_reg[pos_reg] <= 1'b1;
            rd_vld_reg <= smp_vld_reg[scnt_reg[AW-1:0]];
        end
    end

    tas_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (div_go_reg),
        .dividend  (dvd_reg),
        .divisor   (dvs_reg),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pos_reg       <= '0;
            filled_reg    <= 1'b0;
            rpos_reg      <= '0;
            temp_now_reg  <= '0;
            temp_prev_reg <= '0;
            time_now_reg  <= '0;
            time_prev_reg <= '0;
            slope_reg     <= '0;
            upd_reg       <= 1'b0;
            div_go_reg    <= 1'b0;
            pipe_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < RATE_DEPTH; i++)
                rate_ring_reg[i] <= '0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        upd_reg    <= 1'b0;
                        now_in_reg <= sample.now_ms;
                        scnt_reg   <= '0;
                        acc_reg    <= '0;
                        pipe_reg   <= 1'b0;
                        if (sw_reg == 7'd0)
                            state_reg <= S_DONE;
                        else
                        begin
                            pos_reg <= pos_wrap ? '0 : AW'(pos_inc);
                            if (pos_wrap)
                                filled_reg <= 1'b1;
                            if (time_now_reg != time_prev_reg)
                                state_reg <= S_RMUL;
                            else if (pos_wrap || filled_reg)
                                state_reg <= S_ASUM;
                            else
                                state_reg <= S_DONE;
                        end
                    end
                end
                S_RMUL:
                begin
                    dvd_reg    <= DVD_W'({num_prod, 16'h0000});
                    dvs_reg    <= DVS_W'(den_prod);
                    neg_reg    <= d_temp[24] ^ d_time[31];
                    div_go_reg <= 1'b1;
                    state_reg  <= S_RDIV;
                end
                S_RDIV:
                begin
                    if (div_done)
                        state_reg <= S_RPUSH;
                end
                S_RPUSH:
                begin
                    rate_ring_reg[rpos_reg] <= rate_sat;
                    rpos_reg  <= (rpos_inc >= m_eff) ? '0 : RAW'(rpos_inc);
                    rcnt_reg  <= '0;
                    rsum_reg  <= '0;
                    state_reg <= S_SSUM;
                end
                S_SSUM:
                begin
                    if (rcnt_reg == m_eff)
                    begin
                        dvd_reg    <= DVD_W'(rsum_reg[RSUM_W-1] ? -rsum_reg : rsum_reg);
                        dvs_reg    <= DVS_W'(m_eff);
                        neg_reg    <= rsum_reg[RSUM_W-1];
                        div_go_reg <= 1'b1;
                        state_reg  <= S_SDIV;
                    end
                    else
                    begin
                        rsum_reg <= rsum_reg + RSUM_W'(rate_ring_reg[rcnt_reg[RAW-1:0]]);
                        rcnt_reg <= rcnt_reg + 1'b1;
                    end
                end
                S_SDIV:
                begin
                    if (div_done)
                    begin
                        slope_reg <= neg_reg ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
                        state_reg <= filled_reg ? S_ASUM : S_DONE;
                    end
                end
                S_ASUM:
                begin
                    // issue one read per cycle, add the registered data in the next cycle
                    if (scnt_reg != n_eff)
                        scnt_reg <= scnt_reg + 1'b1;
                    pipe_reg <= scnt_reg != n_eff;
                    if (pipe_reg && rd_vld_reg)
                        acc_reg <= acc_reg + SUM_W'(rd_data_reg);
                    if ((scnt_reg == n_eff) && !pipe_reg)
                    begin
                        dvd_reg    <= DVD_W'(acc_reg[SUM_W-1] ? -acc_reg : acc_reg);
                        dvs_reg    <= DVS_W'(n_eff);
                        neg_reg    <= acc_reg[SUM_W-1];
                        div_go_reg <= 1'b1;
                        state_reg  <= S_ADIV;
                    end
                end
                S_ADIV:
                begin
                    if (div_done)
                        state_reg <= S_AFIN;
                end
                S_AFIN:
                begin
                    temp_prev_reg <= temp_now_reg;
                    temp_now_reg  <= q_rnd[23:0];
                    time_prev_reg <= time_now_reg;
                    time_now_reg  <= now_in_reg;
                    upd_reg       <= 1'b1;
                    state_reg     <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DONE) && out_free)
        begin
            out_reg.avg_temp    <= temp_now_reg;
            out_reg.avg_valid   <= filled_reg;
            out_reg.avg_updated <= upd_reg;
            out_reg.slope_q16   <= slope_reg;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign result    = out_reg;

endmodule

// ===== rtl/tas_check.sv =====
// ----------------------------------------------------------------------------
// tas_check
// Port-level checks for the temperature average and slope block.
// ----------------------------------------------------------------------------
module tas_check (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input tas_pkg::result_t result
);
    import tas_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result))
        else $error("result changed while stalled");

    // a new average implies a filled ring
    a_upd_filled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result.avg_updated |-> result.avg_valid)
        else $error("average updated before ring filled");

    // one request at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

endmodule

bind temperature_average_and_slope tas_check u_tas_check (.*);
